/* rtl/sctf_pkg.sv */
// ----------------------------------------------------------------------------
// sctf_pkg
// Shared types and constants for the sector cache tag and policy controller.
// ----------------------------------------------------------------------------
package sctf_pkg;

    localparam int SLOT_W      = 6;
    localparam int SECTOR_W    = 32;
    localparam int OP_W        = 2;
    localparam int ENTRIES_DEF = 64;

    // operation codes
    localparam logic [OP_W-1:0] OP_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

    // request beat
    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [SECTOR_W-1:0] sector;
    } t_in_beat;

    // result beat
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic                hit;
        logic                fetch;
        logic                writeback_valid;
        logic [SECTOR_W-1:0] writeback_sector;
        logic                last;
    } t_out_beat;

    // one cache entry as it travels around the ring
    typedef struct packed {
        logic [SECTOR_W-1:0] tag;
        logic                valid;
        logic                dirty;
    } t_entry;

    // ring control from the controller: rotate enable and the entry that
    // re-enters at the tail
    typedef struct packed {
        logic   shift;
        t_entry tail;
    } t_ring_ctl;

endpackage

/* rtl/sctf_cell.sv */
// ----------------------------------------------------------------------------
// sctf_cell
// One entry of the rotating tag ring: tag, valid and dirty mark.
// ----------------------------------------------------------------------------
module sctf_cell
    import sctf_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    logic [SECTOR_W-1:0] r_tag;
    logic                r_valid;
    logic                r_dirty;

    // marks: cleared by reset, take the neighbor's marks on a shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dirty <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
            r_dirty <= i_entry.dirty;
        end
    end

    // tag: no reset, only read behind a valid mark
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_tag <= i_entry.tag;
        end
    end

    assign o_entry.tag   = r_tag;
    assign o_entry.valid = r_valid;
    assign o_entry.dirty = r_dirty;

endmodule

/* rtl/sctf_ring.sv */
// ----------------------------------------------------------------------------
// sctf_ring
// Row of entry cells forming a ring. Each shift moves every entry one place
// toward the head; the controller feeds the (possibly updated) head entry
// back in at the tail.
// ----------------------------------------------------------------------------
module sctf_ring
    import sctf_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ring_ctl i_ctl,
    output t_entry    o_head
);

    t_entry cell_q [ENTRIES];

    genvar k;
    generate
        for (k = 0; k < ENTRIES; k++) begin : g_cell
            t_entry cell_d;
            if (k == ENTRIES - 1) begin : g_tail
                assign cell_d = i_ctl.tail;
            end else begin : g_body
                assign cell_d = cell_q[k+1];
            end
            sctf_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (i_ctl.shift),
                .i_entry (cell_d),
                .o_entry (cell_q[k])
            );
        end
    endgenerate

    assign o_head = cell_q[0];

endmodule

/* rtl/sctf_ctrl.sv */
// ----------------------------------------------------------------------------
// sctf_ctrl
// Sequencer for lookup, replacement and flush passes over the entry ring,
// plus the result output register.
// ----------------------------------------------------------------------------
module sctf_ctrl
    import sctf_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat,
    input  t_entry    i_head,
    output t_ring_ctl o_ring
);

    localparam int            IW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_LOOKUP    = 7'b0000010,
        S_REPLACE   = 7'b0000100,
        S_HIT_OUT   = 7'b0001000,
        S_MISS_OUT  = 7'b0010000,
        S_FLUSH     = 7'b0100000,
        S_FLUSH_END = 7'b1000000
    } t_state;

    t_state              r_state,    n_state;
    logic [IW-1:0]       r_idx,      n_idx;
    logic [IW-1:0]       r_fifo,     n_fifo;
    logic                r_write,    n_write;
    logic [SECTOR_W-1:0] r_sector,   n_sector;
    logic                r_found,    n_found;
    logic [IW-1:0]       r_hit_slot, n_hit_slot;
    logic                r_vic_wb,   n_vic_wb;
    logic [SECTOR_W-1:0] r_vic_tag,  n_vic_tag;
    logic                r_pend_v,   n_pend_v;
    logic [IW-1:0]       r_pend_slot, n_pend_slot;
    logic [SECTOR_W-1:0] r_pend_tag, n_pend_tag;
    logic                r_out_valid, n_out_valid;
    t_out_beat           r_out_beat, n_out_beat;

    logic          out_free;
    logic          head_match;
    logic          head_dirty;
    logic          at_victim;
    logic          pass_end;
    logic [IW-1:0] idx_inc;

    assign out_free   = !r_out_valid || i_out_ready;
    assign head_match = i_head.valid && (i_head.tag == r_sector);
    assign head_dirty = i_head.valid && i_head.dirty;
    assign at_victim  = (r_idx == r_fifo);
    assign pass_end   = (r_idx == LAST_IDX);
    assign idx_inc    = pass_end ? '0 : r_idx + IW'(1);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_fifo      = r_fifo;
        n_write     = r_write;
        n_sector    = r_sector;
        n_found     = r_found;
        n_hit_slot  = r_hit_slot;
        n_vic_wb    = r_vic_wb;
        n_vic_tag   = r_vic_tag;
        n_pend_v    = r_pend_v;
        n_pend_slot = r_pend_slot;
        n_pend_tag  = r_pend_tag;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_beat  = r_out_beat;
        o_ring.shift = 1'b0;
        o_ring.tail  = i_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx    = '0;
                    n_found  = 1'b0;
                    n_pend_v = 1'b0;
                    n_vic_wb = 1'b0;
                    n_write  = (i_in_beat.operation == OP_WRITE);
                    n_sector = i_in_beat.sector;
                    case (i_in_beat.operation)
                        OP_READ, OP_WRITE: n_state = S_LOOKUP;
                        OP_FLUSH:          n_state = S_FLUSH;
                        default:           n_state = S_IDLE;
                    endcase
                end
            end

            // full rotation: compare at the head, note the victim entry
            S_LOOKUP: begin
                o_ring.shift = 1'b1;
                if (head_match && !r_found) begin
                    n_found    = 1'b1;
                    n_hit_slot = r_idx;
                    if (r_write) begin
                        o_ring.tail.dirty = 1'b1;
                    end
                end
                if (at_victim) begin
                    n_vic_wb  = head_dirty;
                    n_vic_tag = i_head.tag;
                end
                n_idx = idx_inc;
                if (pass_end) begin
                    n_state = (r_found || head_match) ? S_HIT_OUT : S_REPLACE;
                end
            end

            // second rotation: overwrite the victim as it passes the head
            S_REPLACE: begin
                o_ring.shift = 1'b1;
                if (at_victim) begin
                    o_ring.tail.tag   = r_sector;
                    o_ring.tail.valid = 1'b1;
                    o_ring.tail.dirty = r_write;
                end
                n_idx = idx_inc;
                if (pass_end) begin
                    n_state = S_MISS_OUT;
                end
            end

            S_HIT_OUT: begin
                if (out_free) begin
                    n_out_valid                 = 1'b1;
                    n_out_beat.slot             = SLOT_W'(r_hit_slot);
                    n_out_beat.hit              = 1'b1;
                    n_out_beat.fetch            = 1'b0;
                    n_out_beat.writeback_valid  = 1'b0;
                    n_out_beat.writeback_sector = '0;
                    n_out_beat.last             = 1'b1;
                    n_state                     = S_IDLE;
                end
            end

            S_MISS_OUT: begin
                if (out_free) begin
                    n_out_valid                 = 1'b1;
                    n_out_beat.slot             = SLOT_W'(r_fifo);
                    n_out_beat.hit              = 1'b0;
                    n_out_beat.fetch            = 1'b1;
                    n_out_beat.writeback_valid  = r_vic_wb;
                    n_out_beat.writeback_sector = r_vic_wb ? r_vic_tag : '0;
                    n_out_beat.last             = 1'b1;
                    n_fifo                      = (r_fifo == LAST_IDX) ? '0
                                                  : r_fifo + IW'(1);
                    n_state                     = S_IDLE;
                end
            end

            // one dirty entry is held back so the final beat can carry last
            S_FLUSH: begin
                if (!(head_dirty && r_pend_v && !out_free)) begin
                    o_ring.shift = 1'b1;
                    if (head_dirty) begin
                        o_ring.tail.dirty = 1'b0;
                        if (r_pend_v) begin
                            n_out_valid                 = 1'b1;
                            n_out_beat.slot             = SLOT_W'(r_pend_slot);
                            n_out_beat.hit              = 1'b0;
                            n_out_beat.fetch            = 1'b0;
                            n_out_beat.writeback_valid  = 1'b1;
                            n_out_beat.writeback_sector = r_pend_tag;
                            n_out_beat.last             = 1'b0;
                        end
                        n_pend_v    = 1'b1;
                        n_pend_slot = r_idx;
                        n_pend_tag  = i_head.tag;
                    end
                    n_idx = idx_inc;
                    if (pass_end) begin
                        n_state = S_FLUSH_END;
                    end
                end
            end

            S_FLUSH_END: begin
                if (out_free) begin
                    n_out_valid                 = 1'b1;
                    n_out_beat.slot             = r_pend_v ? SLOT_W'(r_pend_slot) : '0;
                    n_out_beat.hit              = 1'b0;
                    n_out_beat.fetch            = 1'b0;
                    n_out_beat.writeback_valid  = r_pend_v;
                    n_out_beat.writeback_sector = r_pend_v ? r_pend_tag : '0;
                    n_out_beat.last             = 1'b1;
                    n_state                     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fifo      <= '0;
            r_found     <= 1'b0;
            r_pend_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fifo      <= n_fifo;
            r_found     <= n_found;
            r_pend_v    <= n_pend_v;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_write     <= n_write;
        r_sector    <= n_sector;
        r_hit_slot  <= n_hit_slot;
        r_vic_wb    <= n_vic_wb;
        r_vic_tag   <= n_vic_tag;
        r_pend_slot <= n_pend_slot;
        r_pend_tag  <= n_pend_tag;
        r_out_beat  <= n_out_beat;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

/* rtl/sector_cache_fifo_writeback_core.sv */
// ----------------------------------------------------------------------------
// sector_cache_fifo_writeback_core
// Tag and policy controller for a fully associative write-back sector cache
// with FIFO replacement.
// ----------------------------------------------------------------------------
// The entries (tag, valid, dirty) live in a ring of ENTRIES cells that
// rotates one place per cycle during a pass, unless a flush is held by the
// consumer, past a single compare and update point at its head, so one
// request takes whole rotations: a read or write hit one, a miss two
// (lookup rotation, then a rotation that installs the new tag in the FIFO
// victim slot), a flush one, and an unused operation code none. A request
// waits while it must emit a result beat that the consumer still holds. One
// request is worked on at a time; the result register lets the next request
// in while the last beat waits.
// ----------------------------------------------------------------------------
module sector_cache_fifo_writeback_core
    import sctf_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_beat
);

    t_ring_ctl ring_ctl;
    t_entry    ring_head;

    sctf_ring #(
        .ENTRIES (ENTRIES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ring_ctl),
        .o_head  (ring_head)
    );

    sctf_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat),
        .i_head      (ring_head),
        .o_ring      (ring_ctl)
    );

`ifndef SYNTH
    // ring never rotates while a new request can be taken
    a_no_shift_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_ctl.shift |-> !o_in_ready)
        else $error("ring rotating while accepting requests");

    // a hit never asks for a fetch or a write-back
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.hit) |->
            (!o_out_beat.fetch && !o_out_beat.writeback_valid && o_out_beat.last))
        else $error("hit beat with fetch or write-back");

    // a fetch is the only beat of its request
    a_fetch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_beat.fetch) |-> o_out_beat.last)
        else $error("fetch beat not marked last");

    // no write-back means a zero sector field
    a_wb_sector_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_beat.writeback_valid) |->
            (o_out_beat.writeback_sector == '0))
        else $error("write-back sector set without write-back");
`endif

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sector_cache_fifo_writeback_core. A directed table
// walks reset, extreme sectors, hits, misses, flushes and the spare opcode,
// then random traffic runs in four idle/stall phases. Every request beat that
// the core accepts goes through a shadow copy of the tag/valid/dirty/FIFO
// state, and every result beat is compared against the oldest expectation.
// ----------------------------------------------------------------------------
module testbench
    import sctf_pkg::*;
();

    localparam int ENTRIES        = ENTRIES_DEF;
    localparam int POOL_SIZE      = 96;
    localparam int PHASE_ITEMS    = 103;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 2 * ENTRIES + 8;
    localparam int DIR_ROWS       = 19;

    // opcode the core must ignore
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // one directed row; result is only meaningful when pinned is set
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [SECTOR_W-1:0] sector;
        logic                pinned;
        t_out_beat           result;
    } t_row;

    localparam t_row DIR_TABLE [DIR_ROWS] = '{
        '{OP_FLUSH, 32'h0000_0000, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b1}},
        '{OP_READ,  32'h0000_0000, 1'b1, '{6'd0, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1}},
        '{OP_READ,  32'h0000_0000, 1'b1, '{6'd0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b1}},
        '{OP_WRITE, 32'hFFFF_FFFF, 1'b1, '{6'd1, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1}},
        '{OP_WRITE, 32'hFFFF_FFFF, 1'b1, '{6'd1, 1'b1, 1'b0, 1'b0, 32'h0, 1'b1}},
        '{OP_WRITE, 32'h0000_0000, 1'b1, '{6'd0, 1'b1, 1'b0, 1'b0, 32'h0, 1'b1}},
        '{OP_SPARE, 32'h1234_5678, 1'b0, '0},
        '{OP_FLUSH, 32'hDEAD_BEEF, 1'b0, '0},
        '{OP_FLUSH, 32'h0000_0000, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b1}},
        '{OP_WRITE, 32'hAAAA_AAAA, 1'b1, '{6'd2, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1}},
        '{OP_WRITE, 32'h5555_5555, 1'b1, '{6'd3, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1}},
        '{OP_READ,  32'h8000_0000, 1'b1, '{6'd4, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1}},
        '{OP_READ,  32'h0000_0001, 1'b1, '{6'd5, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1}},
        '{OP_WRITE, 32'h0000_0001, 1'b1, '{6'd5, 1'b1, 1'b0, 1'b0, 32'h0, 1'b1}},
        '{OP_SPARE, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_READ,  32'h7FFF_FFFF, 1'b1, '{6'd6, 1'b0, 1'b1, 1'b0, 32'h0, 1'b1}},
        '{OP_FLUSH, 32'h0000_0000, 1'b0, '0},
        '{OP_READ,  32'hAAAA_AAAA, 1'b1, '{6'd2, 1'b1, 1'b0, 1'b0, 32'h0, 1'b1}},
        '{OP_FLUSH, 32'hFFFF_FFFF, 1'b1, '{6'd0, 1'b0, 1'b0, 1'b0, 32'h0, 1'b1}}
    };

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_beat  i_in_beat   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_beat o_out_beat;

    // shadow cache state
    logic [SECTOR_W-1:0] shadow_tag   [ENTRIES];
    bit                  shadow_valid [ENTRIES];
    bit                  shadow_dirty [ENTRIES];
    logic [SLOT_W-1:0]   shadow_fifo_ptr = '0;

    t_out_beat           step_results [$];
    t_out_beat           pending_results [$];
    t_row                request_notes [$];
    logic [SECTOR_W-1:0] sector_pool [POOL_SIZE];

    int mismatches   = 0;
    int quiet_cycles = 0;
    int idle_pct     = 0;
    int stall_pct    = 0;
    t_row accepted_note;

    sector_cache_fifo_writeback_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    always #5 i_clk = ~i_clk;

    // shadow model of one request: fills step_results with its result beats
    function automatic void cache_policy_step(t_in_beat req);
        int        hit_slot;
        bit        have_held;
        t_out_beat held;
        logic [SLOT_W-1:0] victim;

        step_results.delete();
        hit_slot  = -1;
        have_held = 1'b0;
        held      = '0;
        case (req.operation)
            OP_READ, OP_WRITE: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (hit_slot < 0 && shadow_valid[i] && shadow_tag[i] == req.sector)
                        hit_slot = i;
                end
                if (hit_slot >= 0) begin
                    if (req.operation == OP_WRITE)
                        shadow_dirty[hit_slot] = 1'b1;
                    held.slot = SLOT_W'(hit_slot);
                    held.hit  = 1'b1;
                end else begin
                    victim     = shadow_fifo_ptr;
                    held.slot  = victim;
                    held.fetch = 1'b1;
                    if (shadow_valid[victim] && shadow_dirty[victim]) begin
                        held.writeback_valid  = 1'b1;
                        held.writeback_sector = shadow_tag[victim];
                    end
                    shadow_tag[victim]   = req.sector;
                    shadow_valid[victim] = 1'b1;
                    shadow_dirty[victim] = (req.operation == OP_WRITE);
                    shadow_fifo_ptr = (victim == SLOT_W'(ENTRIES - 1)) ? '0 : victim + 1'b1;
                end
                held.last = 1'b1;
                step_results.push_back(held);
            end
            OP_FLUSH: begin
                // one beat per dirty slot (a single beat without write-back if none), last marks the final one
                for (int i = 0; i < ENTRIES; i++) begin
                    if (shadow_valid[i] && shadow_dirty[i]) begin
                        if (have_held)
                            step_results.push_back(held);
                        held = '0;
                        held.slot             = SLOT_W'(i);
                        held.writeback_valid  = 1'b1;
                        held.writeback_sector = shadow_tag[i];
                        have_held       = 1'b1;
                        shadow_dirty[i] = 1'b0;
                    end
                end
                held.last = 1'b1;
                step_results.push_back(held);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_result(t_out_beat got);
        t_out_beat want;

        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending: %p", got));
        end else begin
            want = pending_results.pop_front();
            if (got.slot !== want.slot)
                report_mismatch($sformatf("slot %0d, want %0d", got.slot, want.slot));
            if (got.hit !== want.hit)
                report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
            if (got.fetch !== want.fetch)
                report_mismatch($sformatf("fetch %b, want %b", got.fetch, want.fetch));
            if (got.writeback_valid !== want.writeback_valid)
                report_mismatch($sformatf("writeback_valid %b, want %b",
                                          got.writeback_valid, want.writeback_valid));
            if (got.writeback_sector !== want.writeback_sector)
                report_mismatch($sformatf("writeback_sector %h, want %h",
                                          got.writeback_sector, want.writeback_sector));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %b, want %b", got.last, want.last));
        end
    endtask

    // monitor: predict on request beats, check result beats
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                accepted_note = request_notes.pop_front();
                cache_policy_step(i_in_beat);
                if (accepted_note.pinned)
                    pending_results.push_back(accepted_note.result);
                else
                    foreach (step_results[k]) pending_results.push_back(step_results[k]);
            end
            if (o_out_valid && i_out_ready)
                check_result(o_out_beat);
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // present one request beat, optionally after a gap, and wait for acceptance
    task automatic send_request(t_in_beat req, t_row note);
        int gap;

        gap = 0;
        if ($urandom_range(0, 99) < idle_pct)
            gap = $urandom_range(1, 3 * ENTRIES + 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        request_notes.push_back(note);
        i_in_valid <= 1'b1;
        i_in_beat  <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // sender holds off until every pending result beat is out; the first
    // edge lets the monitor log the beat accepted just before
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [SECTOR_W-1:0] pick_sector();
        int unsigned r;

        r = $urandom_range(0, 99);
        if (r < 60)
            return sector_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 85)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return ~(32'h1 << $urandom_range(0, 31));
        endcase
    endfunction

    function automatic t_in_beat pick_request();
        t_in_beat    req;
        int unsigned r;

        r = $urandom_range(0, 99);
        req.sector = pick_sector();
        if (r < 5)
            req.operation = OP_FLUSH;
        else if (r < 8)
            req.operation = OP_SPARE;
        else
            req.operation = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        return req;
    endfunction

    // phase settings: none, sender idle, receiver stall, both
    int phase_idle  [4] = '{0, 72, 0, 14};
    int phase_stall [4] = '{0, 0, 72, 14};

    initial begin
        t_in_beat req;
        t_row     plain;
        int       sent;

        plain = '0;
        foreach (sector_pool[k]) sector_pool[k] = $urandom;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (DIR_TABLE[k]) begin
            req.operation = DIR_TABLE[k].op;
            req.sector    = DIR_TABLE[k].sector;
            send_request(req, DIR_TABLE[k]);
        end
        drain_results();

        // random phases
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            sent = 0;
            if (ph == 2) begin
                // fill every slot dirty, then flush all of them under stall
                for (int k = 0; k < ENTRIES; k++) begin
                    req.operation = OP_WRITE;
                    req.sector    = $urandom;
                    send_request(req, plain);
                end
                req.operation = OP_FLUSH;
                req.sector    = $urandom;
                send_request(req, plain);
                sent = ENTRIES + 1;
            end
            while (sent < PHASE_ITEMS) begin
                req = pick_request();
                send_request(req, plain);
                if (req.operation != OP_SPARE)
                    sent++;
            end
            drain_results();
        end

        // let any stray beats show up
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending_results.size() != 0) begin
            report_mismatch($sformatf("result never arrived: %p", pending_results[0]));
            void'(pending_results.pop_front());
        end
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
